// File: rtl/core/mrect_pkg.sv
// Shared types and constants for the maximal ones rectangle block.
// Used by mrect_stack and maximal_ones_rectangle_top; no dependencies.
package mrect_pkg;

    localparam int MAX_COLS_DEF   = 64;
    localparam int MAX_HEIGHT_DEF = 255;

    localparam int CFG_W       = 7;
    localparam int AREA_W      = 14;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_W-1:0]  CFG_RESET  = 7'd64;
    localparam logic [AREA_W-1:0] AREA_LIMIT = 14'h3FFF;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_UPD,
        S_RD,
        S_CMP,
        S_POP2,
        S_FIN
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_cmd;

endpackage

// File: rtl/core/mrect_stack.sv
// Monotonic column stack: entries held in a one-port synchronous memory,
// with the top and the entry below it mirrored in registers. Uses mrect_pkg.
module mrect_stack #(
    parameter int MAX_COLS   = mrect_pkg::MAX_COLS_DEF,
    parameter int MAX_HEIGHT = mrect_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  mrect_pkg::t_stk_cmd                         i_cmd,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] i_push_idx,
    input  logic [$clog2(MAX_HEIGHT + 1)-1:0]           i_push_h,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] o_top_idx,
    output logic [$clog2(MAX_HEIGHT + 1)-1:0]           o_top_h,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] o_sub_idx,
    output logic [$clog2(MAX_COLS + 1)-1:0]             o_depth
);
    import mrect_pkg::*;

    localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NW = $clog2(MAX_COLS + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [IW+HW-1:0] r_mem [MAX_COLS];
    logic [IW+HW-1:0] r_rd;
    logic [IW+HW-1:0] r_top;
    logic [IW+HW-1:0] r_sub;
    logic [NW-1:0]    r_depth;
    logic             r_reload;
    logic [IW-1:0]    rd_addr;

    assign rd_addr = IW'(r_depth - NW'(3));

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_depth[IW-1:0]] <= {i_push_idx, i_push_h};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Payload mirrors: top and the entry just below it
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_sub <= r_top;
            r_top <= {i_push_idx, i_push_h};
        end else if (i_cmd.pop) begin
            r_top <= r_sub;
        end else if (r_reload) begin
            r_sub <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_reload <= 1'b0;
        end else begin
            r_reload <= 1'b0;
            if (i_cmd.push) begin
                r_depth <= r_depth + NW'(1);
            end else if (i_cmd.pop) begin
                r_depth  <= r_depth - NW'(1);
                // refill the lower mirror only when an entry remains below the new top
                r_reload <= (int'(r_depth) >= 3);
            end
        end
    end

    assign o_top_idx = r_top[IW+HW-1:HW];
    assign o_top_h   = r_top[HW-1:0];
    assign o_sub_idx = r_sub[IW+HW-1:HW];
    assign o_depth   = r_depth;

endmodule

// File: rtl/core/maximal_ones_rectangle_top.sv
// Top level of the maximal ones rectangle block: column height memory,
// row pass sequencer and result register. Uses mrect_pkg and mrect_stack.
//
//  channel   dir  signals                                   beat
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready/tdata/tlast one matrix cell
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready/tdata     one max area
//  cfg       in   i_cfg_we/i_cfg_wdata                      num_cols write
//
// A cell that does not end a row is a height read, then a write back.
// A row end adds a pass over its W cells and one sentinel column past them:
// one height memory read and compare per column, plus an S_POP2 step per pop
// (stack memory refill and area compare after the registered multiply).
// After reset, and after each last cell, a clearing pass over all MAX_COLS
// entries zeroes the heights; no cell is taken then. The result waits in an output
// register; a next last cell holds only if that register is still full.
module maximal_ones_rectangle_top #(
    parameter int MAX_COLS   = mrect_pkg::MAX_COLS_DEF,
    parameter int MAX_HEIGHT = mrect_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [mrect_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // [0] cell_req
    input  logic                               i_s_axis_tlast,  // last_cell
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [mrect_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,  // [13:0] max_area
    input  logic                               i_cfg_we,
    input  logic [mrect_pkg::CFG_W-1:0]        i_cfg_wdata      // num_cols
);
    import mrect_pkg::*;

    localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NW = $clog2(MAX_COLS + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = HW + NW;
    localparam logic [HW-1:0] HMAX = HW'(MAX_HEIGHT);
    localparam logic [NW-1:0] NMAX = NW'(MAX_COLS);
    localparam logic [IW-1:0] LAST_ADDR = IW'(MAX_COLS - 1);

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_num_cols;
    logic [IW-1:0]      r_col, n_col;
    logic               r_cell, n_cell;
    logic               r_last, n_last;
    logic [NW-1:0]      r_i, n_i;
    logic [NW-1:0]      r_span, n_span;
    logic [AREA_W-1:0]  r_best, n_best;
    logic [PW-1:0]      r_prod, n_prod;
    logic [IW-1:0]      r_clr, n_clr;
    logic               r_ovalid, n_ovalid;
    logic [AREA_W-1:0]  r_odata, n_odata;

    logic [HW-1:0]      r_hmem [MAX_COLS];
    logic [HW-1:0]      r_hrd;
    logic               h_we, h_re;
    logic [IW-1:0]      h_waddr, h_raddr;
    logic [HW-1:0]      h_wdata;

    t_stk_cmd           stk_cmd;
    logic [IW-1:0]      stk_top_idx, stk_sub_idx;
    logic [HW-1:0]      stk_top_h;
    logic [NW-1:0]      stk_depth;

    logic               s_acc;
    logic [NW-1:0]      n_eff;
    logic [NW-1:0]      filled;
    logic [HW-1:0]      new_h;
    logic [HW-1:0]      cur;
    logic [NW-1:0]      left;
    logic [NW-1:0]      span_w;
    logic [AREA_W-1:0]  area_sat;

    mrect_stack #(
        .MAX_COLS   (MAX_COLS),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (stk_cmd),
        .i_push_idx (IW'(r_i)),
        .i_push_h   (cur),
        .o_top_idx  (stk_top_idx),
        .o_top_h    (stk_top_h),
        .o_sub_idx  (stk_sub_idx),
        .o_depth    (stk_depth)
    );

    // Height memory, registered read
    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_hmem[h_waddr] <= h_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_re) begin
            r_hrd <= r_hmem[h_raddr];
        end
    end

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (r_num_cols == '0) begin
            n_eff = NW'(1);
        end else if (int'(r_num_cols) > MAX_COLS) begin
            n_eff = NMAX;
        end else begin
            n_eff = NW'(r_num_cols);
        end
    end

    assign filled = NW'(r_col) + NW'(1);
    assign new_h  = !r_cell ? '0 : ((r_hrd < HMAX) ? r_hrd + HW'(1) : r_hrd);
    // the sentinel column past the span reads as zero and drains the stack
    assign cur    = (r_i == r_span) ? '0 : r_hrd;
    assign left   = (int'(stk_depth) > 1) ? NW'(stk_sub_idx) + NW'(1) : '0;
    assign span_w = r_i - left;
    assign area_sat = (32'(r_prod) > 32'(AREA_LIMIT)) ? AREA_LIMIT : AREA_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_num_cols <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_col    <= '0;
            r_i      <= '0;
            r_span   <= '0;
            r_best   <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_i      <= n_i;
            r_span   <= n_span;
            r_best   <= n_best;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell  <= n_cell;
        r_last  <= n_last;
        r_prod  <= n_prod;
        r_odata <= n_odata;
    end

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_cell   = r_cell;
        n_last   = r_last;
        n_i      = r_i;
        n_span   = r_span;
        n_best   = r_best;
        n_prod   = r_prod;
        n_clr    = r_clr;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        h_we     = 1'b0;
        h_re     = 1'b0;
        h_waddr  = r_col;
        h_raddr  = r_col;
        h_wdata  = new_h;
        stk_cmd  = '0;
        o_s_axis_tready = 1'b0;

        unique case (r_state)
            S_CLR: begin
                h_we    = 1'b1;
                h_waddr = r_clr;
                h_wdata = '0;
                n_clr   = r_clr + IW'(1);
                if (r_clr == LAST_ADDR) begin
                    n_clr   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                h_re = 1'b1;
                if (s_acc) begin
                    n_cell  = i_s_axis_tdata[0];
                    n_last  = i_s_axis_tlast;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                h_we = 1'b1;
                if (filled >= n_eff || r_last) begin
                    n_span  = filled;
                    n_i     = '0;
                    n_col   = '0;
                    n_state = S_RD;
                end else begin
                    n_col   = IW'(filled);
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                h_re    = 1'b1;
                h_raddr = IW'(r_i);
                n_state = S_CMP;
            end
            S_CMP: begin
                priority if (stk_depth != '0 && stk_top_h >= cur) begin
                    stk_cmd.pop = 1'b1;
                    n_prod      = PW'(stk_top_h) * PW'(span_w);
                    n_state     = S_POP2;
                end else if (r_i != r_span) begin
                    stk_cmd.push = 1'b1;
                    n_i          = r_i + NW'(1);
                    n_state      = S_RD;
                end else begin
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_POP2: begin
                if (area_sat > r_best) begin
                    n_best = area_sat;
                end
                n_state = S_CMP;
            end
            S_FIN: begin
                // hold while the previous result is still unclaimed
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_best;
                    n_best   = '0;
                    n_col    = '0;
                    n_state  = S_CLR;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_odata);

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == S_UPD))
        else $error("accepted cell did not move to height update");

    a_idle_stack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (stk_depth == '0))
        else $error("stack not drained between rows");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (stk_depth <= r_i))
        else $error("stack deeper than columns visited");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside the final state");

endmodule
